// File: sv/linear_array_deque_assert.svh
// ----------------------------------------------------------------------------
// Linear array deque assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LINEAR_ARRAY_DEQUE_ASSERT_SVH
`define LINEAR_ARRAY_DEQUE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LAD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LAD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/lad_pkg.sv
// ----------------------------------------------------------------------------
// Linear array deque package
// Command and status codes, widths and the controller command bundle.
// ----------------------------------------------------------------------------
package lad_pkg;

	localparam int DATA_W       = 32;
	localparam int DEF_CAPACITY = 16;

	typedef enum logic [1:0] {
		CMD_PUSH_REAR  = 2'd0,
		CMD_PUSH_FRONT = 2'd1,
		CMD_POP_FRONT  = 2'd2,
		CMD_POP_REAR   = 2'd3
	} lad_cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} lad_status_t;

	// Strobes from the controller to the datapath.
	typedef struct packed {
		logic capture;  // latch the incoming word
		logic exec;     // do the storage access and index update
		logic load;     // move the result into the output register
	} lad_ctrl_t;

endpackage

// File: sv/linear_array_deque.sv
// ----------------------------------------------------------------------------
// Linear array deque
// Double-ended queue held in a fixed linear array with front and rear ends.
// ----------------------------------------------------------------------------
// The deque keeps up to CAPACITY 32-bit elements in a plain (non-circular)
// array. Each input word carries a command (push rear, push front, pop front,
// pop rear) and a push value; each produces exactly one output word with the
// popped value and a status (ok, full at the requested end, or empty). Space
// freed at the front is reused only by front pushes, and space freed at the
// rear only by rear pushes, so a push can report full while the deque holds
// fewer than CAPACITY elements. A failed command changes nothing and returns
// a zero value. One word is handled at a time. The word is captured when it
// is accepted, then the single-port element memory access and index update
// are done, and then the result is loaded into the output register; the load
// waits while the output register still holds a result that has not been
// taken. A new word is taken while a finished result still waits in the
// output register, but only once the previous word has been loaded into it.
// Element memory contents are not cleared at reset; the indices are, and no
// command can read a slot that was never written.
// ----------------------------------------------------------------------------
module linear_array_deque
	import lad_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               command,
	input  logic signed [DATA_W-1:0] push_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] pop_value,
	output logic [1:0]               status
);

	lad_ctrl_t ctrl;

	// The controller walks each word through capture, execute and load.
	lad_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctrl      (ctrl)
	);

	// The datapath holds the elements, both indices and the result.
	lad_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.command    (command),
		.push_value (push_value),
		.pop_value  (pop_value),
		.status     (status)
	);

endmodule

// File: sv/lad_ctrl.sv
// ----------------------------------------------------------------------------
// Linear array deque controller
// Sequences capture, execute and result load; owns both handshakes.
// ----------------------------------------------------------------------------
module lad_ctrl
	import lad_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output lad_ctrl_t ctrl
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	// The output register can take a new result when it is empty or
	// being emptied in this cycle.
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		ctrl.capture = 1'b0;
		ctrl.exec    = 1'b0;
		ctrl.load    = 1'b0;
		case (state_q)
			S_IDLE: ctrl.capture = in_valid;
			S_EXEC: ctrl.exec = 1'b1;
			S_FIN:  ctrl.load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !ctrl.load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: state_q <= S_FIN;
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// File: sv/lad_dp.sv
// ----------------------------------------------------------------------------
// Linear array deque datapath
// Element memory, head and tail indices, and the output register.
// ----------------------------------------------------------------------------
module lad_dp
	import lad_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lad_ctrl_t                ctrl,
	input  logic [1:0]               command,
	input  logic signed [DATA_W-1:0] push_value,
	output logic signed [DATA_W-1:0] pop_value,
	output logic [1:0]               status
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int IW = $clog2(CAPACITY + 1);
	localparam logic [IW-1:0] CAP_IDX = IW'(CAPACITY);
	localparam logic [IW-1:0] ONE_IDX = IW'(1);

	logic [DATA_W-1:0] mem [CAPACITY];

	lad_cmd_t          cmd_q;
	logic [DATA_W-1:0] val_q;
	logic [IW-1:0]     head_q;
	logic [IW-1:0]     tail_q;
	logic [DATA_W-1:0] rd_q;
	logic              pop_ok_q;
	lad_status_t       res_st_q;
	logic [DATA_W-1:0] pop_value_q;
	lad_status_t       status_q;

	logic              is_empty;
	logic              do_wr;
	logic              do_rd;
	logic [IW-1:0]     acc_idx;
	lad_status_t       res_st;

	assign is_empty = (head_q == tail_q);

	// Decide the outcome and the memory slot touched by this command.
	always_comb begin
		do_wr   = 1'b0;
		do_rd   = 1'b0;
		res_st  = ST_OK;
		acc_idx = tail_q;
		case (cmd_q)
			CMD_PUSH_REAR: begin
				acc_idx = tail_q;
				if (tail_q == CAP_IDX) res_st = ST_FULL;
				else do_wr = 1'b1;
			end
			CMD_PUSH_FRONT: begin
				acc_idx = head_q - ONE_IDX;
				if (head_q == '0) res_st = ST_FULL;
				else do_wr = 1'b1;
			end
			CMD_POP_FRONT: begin
				acc_idx = head_q;
				if (is_empty) res_st = ST_EMPTY;
				else do_rd = 1'b1;
			end
			CMD_POP_REAR: begin
				acc_idx = tail_q - ONE_IDX;
				if (is_empty) res_st = ST_EMPTY;
				else do_rd = 1'b1;
			end
			default: res_st = ST_OK;
		endcase
	end

	// Element memory, one access per cycle with registered read data.
	always_ff @(posedge clk) begin
		if (ctrl.exec && do_wr) begin
			mem[acc_idx[AW-1:0]] <= val_q;
		end
		if (ctrl.exec && do_rd) begin
			rd_q <= mem[acc_idx[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_q <= lad_cmd_t'(command);
			val_q <= push_value;
		end
		if (ctrl.exec) begin
			pop_ok_q <= do_rd;
			res_st_q <= res_st;
		end
		if (ctrl.load) begin
			pop_value_q <= pop_ok_q ? rd_q : '0;
			status_q    <= res_st_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else if (ctrl.exec && (do_wr || do_rd)) begin
			case (cmd_q)
				CMD_PUSH_REAR:  tail_q <= tail_q + ONE_IDX;
				CMD_PUSH_FRONT: head_q <= head_q - ONE_IDX;
				CMD_POP_FRONT:  head_q <= head_q + ONE_IDX;
				CMD_POP_REAR:   tail_q <= tail_q - ONE_IDX;
				default: ;
			endcase
		end
	end

	assign pop_value = pop_value_q;
	assign status    = status_q;

endmodule

// File: sv/lad_checker.sv
// ----------------------------------------------------------------------------
// Linear array deque checker
// Port-level assertions on the deque handshakes and result words.
// ----------------------------------------------------------------------------
`include "linear_array_deque_assert.svh"

module lad_checker
	import lad_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [DATA_W-1:0] pop_value,
	input logic [1:0]        status
);

	// A stalled result word holds its contents.
	`LAD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pop_value) && $stable(status), "result word changed while stalled")

	// A failed command never returns a value.
	`LAD_ASSERT_SAME(a_fail_zero, out_valid && (status != ST_OK), pop_value == '0, "failed command returned a nonzero value")

	// Status codes stay within the defined set.
	`LAD_ASSERT_SAME(a_status_code, out_valid, (status == ST_OK) || (status == ST_FULL) || (status == ST_EMPTY), "undefined status code")

	// An accepted word keeps the input closed through its execute and finish states.
	`LAD_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready ##1 !in_ready, "input reopened while a word was in work")

endmodule

bind linear_array_deque lad_checker u_lad_checker (.*);
